>>> hw/rtl/ccc_pkg.sv
// Shared types, constants and calendar helpers for the calendar clock counter.
// Used by every module of the block; depends on nothing else.
package ccc_pkg;

    typedef struct packed {
        logic       action;
        logic [6:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_day;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [5:0] load_second;
    } cmd_word_t;

    typedef struct packed {
        logic [6:0] year_now;
        logic [3:0] month_now;
        logic [4:0] day_now;
        logic [4:0] hour_now;
        logic [5:0] minute_now;
        logic [5:0] second_now;
        logic       second_boundary;
    } status_word_t;

    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_LOAD = 1'b1;

    localparam logic [7:0] TPS_RESET    = 8'd30;
    localparam logic [5:0] SECOND_RESET = 6'd0;
    localparam logic [5:0] MINUTE_RESET = 6'd36;
    localparam logic [4:0] HOUR_RESET   = 5'd14;
    localparam logic [4:0] DAY_RESET    = 5'd25;
    localparam logic [3:0] MONTH_RESET  = 4'd12;
    localparam logic [6:0] YEAR_RESET   = 7'd12;

    localparam logic [6:0] SECONDS_PER_MINUTE = 7'd60;
    localparam logic [6:0] MINUTES_PER_HOUR   = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY      = 6'd24;
    localparam logic [4:0] MONTHS_PER_YEAR    = 5'd12;
    localparam logic [7:0] YEAR_MODULUS       = 8'd100;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [4:0] LONG_MONTH_DAYS = 5'd31;
    localparam logic [4:0] LEAP_FEB_DAYS   = 5'd29;

    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // A month code outside one to twelve counts as a long month.
    function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                                 input logic [6:0] year);
        logic [4:0] days;
        if (month == 4'd0 || month > MONTHS_PER_YEAR[3:0]) begin
            days = LONG_MONTH_DAYS;
        end else if (month == MONTH_FEB && year[1:0] == 2'b00) begin
            days = LEAP_FEB_DAYS;
        end else begin
            days = MONTH_DAYS[month - 4'd1];
        end
        return days;
    endfunction

endpackage

>>> hw/rtl/ccc_stream_if.sv
// Valid/ready channel interface that carries one word of a given type.
// Depends on nothing; the word type comes from ccc_pkg at the instance.
interface ccc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

>>> hw/rtl/ccc_in_stage.sv
// Input register of the calendar clock counter: holds one accepted command word.
// Depends on ccc_pkg and ccc_stream_if.
module ccc_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    ccc_stream_if.sink          cmd,
    input  logic                advance,
    output logic                item_valid,
    output ccc_pkg::cmd_word_t  item
);

    logic               valid_reg;
    logic               valid_next;
    ccc_pkg::cmd_word_t item_reg;

    assign cmd.ready  = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.ready)
        begin
            valid_next = cmd.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            item_reg <= cmd.data;
        end
    end

endmodule

>>> hw/rtl/ccc_time_core.sv
// Prescaler and calendar counters with their carry chain and load path.
// Depends on ccc_pkg for word types, limits, reset values and month lengths.
module ccc_time_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   advance,
    input  ccc_pkg::cmd_word_t     item,
    input  logic [7:0]             ticks_per_second,
    output ccc_pkg::status_word_t  result
);

    logic [7:0] prescale_reg, prescale_next;
    logic [5:0] second_reg, second_next;
    logic [5:0] minute_reg, minute_next;
    logic [4:0] hour_reg, hour_next;
    logic [4:0] day_reg, day_next;
    logic [3:0] month_reg, month_next;
    logic [6:0] year_reg, year_next;

    logic       step;
    logic       boundary;
    logic [7:0] count_inc;
    logic [6:0] second_inc;
    logic [6:0] minute_inc;
    logic [5:0] hour_inc;
    logic [5:0] day_inc;
    logic [4:0] month_inc;
    logic [7:0] year_inc;
    logic [7:0] year_wrapped;
    logic [4:0] month_days;

    assign step         = item_valid && advance;
    assign count_inc    = prescale_reg + 8'd1;
    assign second_inc   = {1'b0, second_reg} + 7'd1;
    assign minute_inc   = {1'b0, minute_reg} + 7'd1;
    assign hour_inc     = {1'b0, hour_reg} + 6'd1;
    assign day_inc      = {1'b0, day_reg} + 6'd1;
    assign month_inc    = {1'b0, month_reg} + 5'd1;
    assign year_inc     = {1'b0, year_reg} + 8'd1;
    assign year_wrapped = (year_inc >= ccc_pkg::YEAR_MODULUS)
                          ? (year_inc - ccc_pkg::YEAR_MODULUS) : year_inc;
    assign month_days   = ccc_pkg::days_in_month(month_reg, year_reg);

    always_comb
    begin
        prescale_next = prescale_reg;
        second_next   = second_reg;
        minute_next   = minute_reg;
        hour_next     = hour_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        boundary      = 1'b0;
        if (item.action == ccc_pkg::ACTION_LOAD)
        begin
            prescale_next = 8'd0;
            second_next   = item.load_second;
            minute_next   = item.load_minute;
            hour_next     = item.load_hour;
            day_next      = item.load_day;
            month_next    = item.load_month;
            year_next     = item.load_year;
        end
        else if (count_inc >= ticks_per_second)
        begin
            prescale_next = 8'd0;
            boundary      = 1'b1;
            if (second_inc < ccc_pkg::SECONDS_PER_MINUTE)
            begin
                second_next = second_inc[5:0];
            end
            else
            begin
                second_next = 6'd0;
                if (minute_inc < ccc_pkg::MINUTES_PER_HOUR)
                begin
                    minute_next = minute_inc[5:0];
                end
                else
                begin
                    minute_next = 6'd0;
                    if (hour_inc < ccc_pkg::HOURS_PER_DAY)
                    begin
                        hour_next = hour_inc[4:0];
                    end
                    else
                    begin
                        hour_next = 5'd0;
                        if (day_inc > {1'b0, month_days})
                        begin
                            day_next = 5'd1;
                            if (month_inc > ccc_pkg::MONTHS_PER_YEAR)
                            begin
                                month_next = 4'd1;
                                year_next  = year_wrapped[6:0];
                            end
                            else
                            begin
                                month_next = month_inc[3:0];
                            end
                        end
                        else
                        begin
                            day_next = day_inc[4:0];
                        end
                    end
                end
            end
        end
        else
        begin
            prescale_next = count_inc;
        end
    end

    assign result = '{year_now:        year_next,
                      month_now:       month_next,
                      day_now:         day_next,
                      hour_now:        hour_next,
                      minute_now:      minute_next,
                      second_now:      second_next,
                      second_boundary: boundary};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= 8'd0;
            second_reg   <= ccc_pkg::SECOND_RESET;
            minute_reg   <= ccc_pkg::MINUTE_RESET;
            hour_reg     <= ccc_pkg::HOUR_RESET;
            day_reg      <= ccc_pkg::DAY_RESET;
            month_reg    <= ccc_pkg::MONTH_RESET;
            year_reg     <= ccc_pkg::YEAR_RESET;
        end
        else if (step)
        begin
            prescale_reg <= prescale_next;
            second_reg   <= second_next;
            minute_reg   <= minute_next;
            hour_reg     <= hour_next;
            day_reg      <= day_next;
            month_reg    <= month_next;
            year_reg     <= year_next;
        end
    end

endmodule

>>> hw/rtl/ccc_out_stage.sv
// Result register of the calendar clock counter, driving the status channel.
// Depends on ccc_pkg and ccc_stream_if.
module ccc_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  ccc_pkg::status_word_t  result,
    output logic                   advance,
    ccc_stream_if.source           status
);

    logic                  valid_reg;
    logic                  valid_next;
    ccc_pkg::status_word_t data_reg;

    assign advance      = !valid_reg || status.ready;
    assign status.valid = valid_reg;
    assign status.data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            data_reg <= result;
        end
    end

endmodule

>>> hw/rtl/calendar_clock_counter.sv
// Calendar clock counter: a prescaled real-time clock with a two-digit year.
// Channels: cmd takes a tick or load word, status gives one time word per
// command word, and cfg writes the ticks-per-second register at any time.
// A tick word advances the prescaler; when it reaches ticks_per_second the
// prescaler clears and the calendar steps one second with full carry into
// minute, hour, day, month and year (February has 29 days in years that
// divide by four). A load word sets every field and clears the prescaler.
// Each status word carries the time after its command and a flag that marks
// a completed second. The command passes an input register and a result
// register before its status word is offered, and one command per cycle is
// accepted for as long as status is drained.
// When status stalls the result register holds its word and the input
// register still takes one more command; cmd.ready drops only while both
// are full. Reset loads 12-25-12 14:36:00, clears the prescaler and sets
// ticks_per_second to 30. The cfg channel is always ready.
// Depends on ccc_pkg, ccc_stream_if, ccc_in_stage, ccc_time_core, ccc_out_stage.
module calendar_clock_counter (
    input  logic          clk,
    input  logic          rst_n,
    ccc_stream_if.sink    cmd,
    ccc_stream_if.source  status,
    ccc_stream_if.sink    cfg
);

    logic                  advance;
    logic                  item_valid;
    ccc_pkg::cmd_word_t    item;
    ccc_pkg::status_word_t result;
    logic [7:0]            tps_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= ccc_pkg::TPS_RESET;
        end
        else if (cfg.valid)
        begin
            tps_reg <= cfg.data;
        end
    end

    ccc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ccc_time_core u_time_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .advance          (advance),
        .item             (item),
        .ticks_per_second (tps_reg),
        .result           (result)
    );

    ccc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .status     (status)
    );

endmodule

>>> hw/rtl/ccc_checker.sv
// Port-level checks for the calendar clock counter, bound to its top level.
// Depends on ccc_stream_if and on the word types of ccc_pkg.
module ccc_checker (
    input logic            clk,
    input logic            rst_n,
    ccc_stream_if.sink     cmd,
    ccc_stream_if.source   status
);

    a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid && !status.ready |=> status.valid && $stable(status.data))
        else $error("status word changed or dropped while stalled");

    a_cmd_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> status.valid && !status.ready)
        else $error("command refused while the status channel was draining");

    a_boundary_second: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid && status.data.second_boundary |->
            status.data.second_now < 6'd60)
        else $error("second boundary left the second out of range");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(status.valid) |-> $past(cmd.valid && cmd.ready, 2))
        else $error("status word without a command two cycles before");

endmodule

bind calendar_clock_counter ccc_checker u_ccc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .status (status)
);
